FILE: rtl/mkt_pkg.sv
// ----------------------------------------------------------------------------
// mkt_pkg
// Shared types, constants and the quarter-wave sine table of the keyer.
// ----------------------------------------------------------------------------
package mkt_pkg;

	// sizing
	localparam int MAX_ELEMENTS   = 16;
	localparam int PHASE_BITS     = 16;
	localparam int SINE_ADDR_BITS = 10;

	localparam int ED_W      = $clog2(MAX_ELEMENTS + 1);
	localparam int QADDR_W   = SINE_ADDR_BITS - 2;
	localparam int QUARTER   = 1 << QADDR_W;
	localparam int SAMPLE_W  = 16;
	localparam int SPU_W     = 16;
	localparam int PSTEP_W   = 15;
	localparam int WORD_W    = 32;
	localparam int UNITS_W   = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DW    = 16;

	localparam int unsigned AMPLITUDE   = 32567;
	localparam int unsigned HALF_PI_Q30 = 32'd1686629713;

	// input actions
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_UNIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP       = 1'd1;

	localparam logic [SPU_W-1:0]   SPU_RESET   = 16'd14400;
	localparam logic [PSTEP_W-1:0] PSTEP_RESET = 15'd1092;

	// code word elements
	localparam logic [1:0]        EL_DIT         = 2'b01;
	localparam logic [1:0]        EL_DAH         = 2'b11;
	localparam logic [1:0]        EL_END_LO      = 2'b00;
	localparam logic [1:0]        EL_END_HI      = 2'b10;
	localparam logic [WORD_W-1:0] WORD_GAP_CODE  = 32'd2;
	localparam logic [UNITS_W-1:0] WORD_GAP_UNITS = 3'd7;
	localparam logic [UNITS_W-1:0] END_GAP_UNITS  = 3'd2;
	localparam logic [UNITS_W-1:0] ELEM_GAP_UNITS = 3'd1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_TONE = 2'd1,
		ST_EGAP = 2'd2,
		ST_FGAP = 2'd3
	} stage_t;

	// quarter-wave magnitude, Taylor series in Q30 (elaboration only)
	function automatic logic [SAMPLE_W-1:0] quarter_sine(input int unsigned q);
		logic [63:0] x;
		logic [63:0] t;
		logic [63:0] sum;
		logic [63:0] v;
		int unsigned n;
		if (q == 0) begin
			return '0;
		end
		if (q >= QUARTER) begin
			return SAMPLE_W'(AMPLITUDE);
		end
		x = (64'(HALF_PI_Q30) * 64'(q)) >> QADDR_W;
		sum = x;
		t = x;
		for (n = 1; n <= 12; n++) begin
			t = (t * x) >> 30;
			t = ((t * x) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n[0]) begin
				sum = (sum >= t) ? sum - t : 64'd0;
			end else begin
				sum = sum + t;
			end
		end
		v = (sum * 64'(AMPLITUDE)) >> 30;
		if (v > 64'(AMPLITUDE)) begin
			v = 64'(AMPLITUDE);
		end
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic logic [QUARTER*SAMPLE_W-1:0] build_qsine();
		logic [QUARTER*SAMPLE_W-1:0] rom;
		rom = '0;
		for (int i = 0; i < QUARTER; i++) begin
			rom[i*SAMPLE_W +: SAMPLE_W] = quarter_sine(i);
		end
		return rom;
	endfunction

	// entry q holds the magnitude for quarter index q (entry 0 is zero)
	localparam logic [QUARTER*SAMPLE_W-1:0] QSINE_ROM = build_qsine();

endpackage

FILE: rtl/mkt_in_if.sv
// ----------------------------------------------------------------------------
// mkt_in_if
// Input channel of the keyer: one action with its code word per word.
// ----------------------------------------------------------------------------
interface mkt_in_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [mkt_pkg::WORD_W-1:0]  code_word;

	modport source (output valid, output action, output code_word, input ready);
	modport sink   (input valid, input action, input code_word, output ready);
endinterface

FILE: rtl/mkt_out_if.sv
// ----------------------------------------------------------------------------
// mkt_out_if
// Result channel of the keyer: one PCM sample and status flags per word.
// ----------------------------------------------------------------------------
interface mkt_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [mkt_pkg::SAMPLE_W-1:0] sample;
	logic                               key_on;
	logic                               busy_res;
	logic                               load_dropped;

	modport source (output valid, output sample, output key_on, output busy_res,
		output load_dropped, input ready);
	modport sink   (input valid, input sample, input key_on, input busy_res,
		input load_dropped, output ready);
endinterface

FILE: rtl/morse_keyer_tone_generator.sv
// ----------------------------------------------------------------------------
// morse_keyer_tone_generator
// Morse keyer with sine sidetone: plays loaded code words one sample per tick.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake       | payload
//  in_ch     | in  | valid / ready   | action, code_word
//  out_ch    | out | valid / ready   | sample, key_on, busy_res, load_dropped
//  cfg       | in  | cfg_we          | cfg_index, cfg_data
//
// One word per cycle sustained while the output is not stalled; a word passes
// the input and result registers in turn; keyer state and sine lie between.
// Reset clears the keyer to idle and loads samples_per_unit 14400 and
// phase_step 1092. A stalled output holds its result; the input register
// keeps one more word, so ready drops only while both are full.
// ----------------------------------------------------------------------------
module morse_keyer_tone_generator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mkt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mkt_pkg::CFG_DW-1:0]           cfg_data,
	mkt_in_if.sink                               in_ch,
	mkt_out_if.source                            out_ch
);

	// configuration
	logic [mkt_pkg::SPU_W-1:0]   spu_q;
	logic [mkt_pkg::PSTEP_W-1:0] pstep_q;

	// input register
	logic                        valid_s1;
	logic                        action_s1;
	logic [mkt_pkg::WORD_W-1:0]  code_word_s1;

	// keyer state
	mkt_pkg::stage_t                 stage_q, stage_d;
	logic [mkt_pkg::WORD_W-1:0]      shift_q, shift_d, shift_src;
	logic [mkt_pkg::ED_W-1:0]        ed_q, ed_d, ed_src;
	logic [mkt_pkg::UNITS_W-1:0]     units_q, units_d;
	logic [mkt_pkg::SPU_W-1:0]       usc_q, usc_d, usc_inc;
	logic [mkt_pkg::PHASE_BITS-1:0]  phase_q, phase_d;
	logic                            load_elem;
	logic [1:0]                      el;

	// result register
	logic                                out_valid_q;
	logic signed [mkt_pkg::SAMPLE_W-1:0] sample_q, sample_d;
	logic                                key_q, key_d;
	logic                                busy_q;
	logic                                drop_q, drop_d;

	logic out_free;
	logic fire_s1;

	// sine lookup
	logic [mkt_pkg::SINE_ADDR_BITS-1:0] k;
	logic [mkt_pkg::SINE_ADDR_BITS-2:0] p;
	logic [mkt_pkg::SINE_ADDR_BITS-2:0] q;
	logic [mkt_pkg::SAMPLE_W-1:0]       mag;
	logic signed [mkt_pkg::SAMPLE_W-1:0] sine;

	assign out_free    = !out_valid_q || out_ch.ready;
	assign fire_s1     = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || out_free;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spu_q   <= mkt_pkg::SPU_RESET;
			pstep_q <= mkt_pkg::PSTEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mkt_pkg::CFG_SAMPLES_PER_UNIT: spu_q   <= cfg_data;
				mkt_pkg::CFG_PHASE_STEP:       pstep_q <= cfg_data[mkt_pkg::PSTEP_W-1:0];
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			action_s1    <= in_ch.action;
			code_word_s1 <= in_ch.code_word;
		end
	end

	// sine: fold the phase into a quarter wave, then sign by the half
	assign k = phase_q[mkt_pkg::PHASE_BITS-1 -: mkt_pkg::SINE_ADDR_BITS];
	assign p = k[mkt_pkg::SINE_ADDR_BITS-2:0];
	assign q = (p > (mkt_pkg::SINE_ADDR_BITS-1)'(mkt_pkg::QUARTER)) ? (~p + 1'b1) : p;

	always_comb begin
		if (q == (mkt_pkg::SINE_ADDR_BITS-1)'(mkt_pkg::QUARTER)) begin
			mag = mkt_pkg::SAMPLE_W'(mkt_pkg::AMPLITUDE);
		end else begin
			mag = mkt_pkg::QSINE_ROM[q[mkt_pkg::QADDR_W-1:0]*mkt_pkg::SAMPLE_W +:
				mkt_pkg::SAMPLE_W];
		end
	end

	assign sine = k[mkt_pkg::SINE_ADDR_BITS-1] ? -$signed(mag) : $signed(mag);

	assign usc_inc = usc_q + 1'b1;

	// next state
	always_comb begin
		stage_d   = stage_q;
		shift_d   = shift_q;
		ed_d      = ed_q;
		units_d   = units_q;
		usc_d     = usc_q;
		phase_d   = phase_q;
		load_elem = 1'b0;
		shift_src = shift_q;
		ed_src    = ed_q;
		el        = '0;
		if (fire_s1) begin
			if (action_s1 == mkt_pkg::ACT_LOAD) begin
				if (stage_q == mkt_pkg::ST_IDLE) begin
					if (code_word_s1 == mkt_pkg::WORD_GAP_CODE) begin
						stage_d = mkt_pkg::ST_FGAP;
						units_d = mkt_pkg::WORD_GAP_UNITS;
						usc_d   = '0;
					end else begin
						load_elem = 1'b1;
						shift_src = code_word_s1;
						ed_src    = '0;
					end
				end
			end else if (stage_q != mkt_pkg::ST_IDLE) begin
				if (stage_q == mkt_pkg::ST_TONE) begin
					phase_d = phase_q + mkt_pkg::PHASE_BITS'(pstep_q);
				end
				// end of one unit
				if (usc_inc == '0 || usc_inc >= spu_q) begin
					usc_d = '0;
					if (units_q > 3'd1) begin
						units_d = units_q - 1'b1;
					end else begin
						unique case (stage_q)
							mkt_pkg::ST_TONE: begin
								stage_d = mkt_pkg::ST_EGAP;
								units_d = mkt_pkg::ELEM_GAP_UNITS;
							end
							mkt_pkg::ST_EGAP: begin
								load_elem = 1'b1;
							end
							mkt_pkg::ST_FGAP: begin
								stage_d = mkt_pkg::ST_IDLE;
								units_d = '0;
							end
							mkt_pkg::ST_IDLE: begin
							end
						endcase
					end
				end else begin
					usc_d = usc_inc;
				end
			end
		end
		// start the next element or the closing gap
		if (load_elem) begin
			el      = shift_src[1:0];
			usc_d   = '0;
			shift_d = shift_src;
			ed_d    = ed_src;
			if (ed_src >= mkt_pkg::ED_W'(mkt_pkg::MAX_ELEMENTS) ||
				!(el == mkt_pkg::EL_DIT || el == mkt_pkg::EL_DAH)) begin
				stage_d = mkt_pkg::ST_FGAP;
				units_d = mkt_pkg::END_GAP_UNITS;
			end else begin
				stage_d = mkt_pkg::ST_TONE;
				units_d = mkt_pkg::UNITS_W'(el);
				shift_d = shift_src >> 2;
				ed_d    = ed_src + 1'b1;
				phase_d = '0;
			end
		end
	end

	// result fields
	always_comb begin
		sample_d = '0;
		key_d    = 1'b0;
		drop_d   = 1'b0;
		if (action_s1 == mkt_pkg::ACT_LOAD) begin
			drop_d = (stage_q != mkt_pkg::ST_IDLE);
		end else if (stage_q == mkt_pkg::ST_TONE) begin
			sample_d = sine;
			key_d    = 1'b1;
		end
	end

	// keyer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= mkt_pkg::ST_IDLE;
			shift_q <= '0;
			ed_q    <= '0;
			units_q <= '0;
			usc_q   <= '0;
			phase_q <= '0;
		end else begin
			stage_q <= stage_d;
			shift_q <= shift_d;
			ed_q    <= ed_d;
			units_q <= units_d;
			usc_q   <= usc_d;
			phase_q <= phase_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			sample_q <= sample_d;
			key_q    <= key_d;
			busy_q   <= (stage_d != mkt_pkg::ST_IDLE);
			drop_q   <= drop_d;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.sample       = sample_q;
	assign out_ch.key_on       = key_q;
	assign out_ch.busy_res     = busy_q;
	assign out_ch.load_dropped = drop_q;

`ifndef NO_ASSERTIONS
	// a sounding tone always leaves the keyer busy
	a_key_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.key_on |-> out_ch.busy_res)
		else $error("key_on without busy_res");

	// a dropped load carries no tone
	a_drop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.load_dropped |-> !out_ch.key_on && out_ch.sample == '0)
		else $error("dropped load produced tone");

	// any active stage still has units to play
	a_units_left: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q != mkt_pkg::ST_IDLE |-> units_q != '0)
		else $error("active stage with no units left");

	// element count never passes the limit
	a_ed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ed_q <= mkt_pkg::ED_W'(mkt_pkg::MAX_ELEMENTS))
		else $error("element count over limit");
`endif

endmodule
